FILE: sv/u2k_pkg.sv
// shared types, constants and the code point to koi-7 mapping table
// no dependencies; used by u2k_decode, u2k_map and utf8_to_koi7_transcoder

package u2k_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 7;
  localparam int unsigned CpW   = 16;

  // sequence tracking phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  // decoder result handed to the mapper
  typedef struct packed {
    logic            emit;
    logic [CpW-1:0]  cp;
  } dec_res_t;

  // cyrillic capitals and small letters share this 32-entry row
  localparam logic [CodeW-1:0] CYR_TAB [32] = '{
    7'h41, 7'h62, 7'h42, 7'h67, 7'h64, 7'h45, 7'h76, 7'h7a,
    7'h69, 7'h6a, 7'h4b, 7'h6c, 7'h4d, 7'h48, 7'h4f, 7'h70,
    7'h50, 7'h43, 7'h54, 7'h59, 7'h66, 7'h58, 7'h63, 7'h7e,
    7'h7b, 7'h7d, 7'h05, 7'h79, 7'h78, 7'h7c, 7'h60, 7'h71
  };

  // latin-1 block, lower case folded to upper case
  function automatic logic [CodeW-1:0] map_latin(input logic [7:0] c);
    logic [CodeW-1:0] r;
    begin
      r = c[7] ? '0 : c[CodeW-1:0];
      case (c)
        8'h00: r = 7'h00;
        8'h5c: r = 7'h1d;
        8'h5e: r = 7'h5c;
        8'h60: r = 7'h00;
        8'h7b: r = 7'h0e;
        8'h7c: r = 7'h5e;
        8'h7d: r = 7'h0f;
        8'h7e: r = 7'h1f;
        8'h7f: r = 7'h00;
        8'hac: r = 7'h1f;
        8'hb0: r = 7'h19;
        8'hd7: r = 7'h06;
        8'hf7: r = 7'h1a;
        default: ;
      endcase
      if (c inside {[8'h61:8'h7a]}) begin
        r = c[CodeW-1:0] - 7'h20;
      end
      return r;
    end
  endfunction

  // cyrillic block u+04xx
  function automatic logic [CodeW-1:0] map_cyr(input logic [7:0] lo);
    logic [4:0]       idx;
    logic [CodeW-1:0] r;
    begin
      idx = lo[4:0] - 5'h10;
      r   = '0;
      case (lo)
        8'h01, 8'h04, 8'h51, 8'h54: r = 7'h45;
        8'h06, 8'h07, 8'h56, 8'h57: r = 7'h49;
        8'h90, 8'h91:               r = 7'h67;
        default: ;
      endcase
      if (lo inside {[8'h10:8'h4f]}) begin
        r = CYR_TAB[idx];
      end
      return r;
    end
  endfunction

  // selected punctuation and mathematical symbols
  function automatic logic [CodeW-1:0] map_sym(input logic [CpW-1:0] cp);
    logic [CodeW-1:0] r;
    begin
      case (cp)
        16'h2015: r = 7'h15;
        16'h2018: r = 7'h10;
        16'h2019: r = 7'h1b;
        16'h2028: r = 7'h0a;
        16'h2032: r = 7'h27;
        16'h203e: r = 7'h5c;
        16'h212f: r = 7'h45;
        16'h2191: r = 7'h16;
        16'h2227: r = 7'h26;
        16'h2228: r = 7'h1e;
        16'h2260: r = 7'h18;
        16'h2261: r = 7'h1d;
        16'h2264: r = 7'h0e;
        16'h2265: r = 7'h0f;
        16'h2283: r = 7'h1c;
        16'h23e8: r = 7'h17;
        16'h25c7: r = 7'h24;
        default:  r = 7'h00;
      endcase
      return r;
    end
  endfunction

endpackage

FILE: sv/u2k_decode.sv
// utf-8 sequence tracker: holds phase, lead byte and second-byte bits
// depends on u2k_pkg for phase_t and dec_res_t

module u2k_decode import u2k_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [ByteW-1:0] in_byte,
  input  logic             last_byte,
  output dec_res_t         res,
  output phase_t           phase
);

  logic [ByteW-1:0] lead_byte, lead_byte_next;
  logic [5:0]       second_bits, second_bits_next;
  phase_t           phase_next;

  // next state and assembled code point for the current beat
  always_comb begin
    res              = '0;
    phase_next       = PH_IDLE;
    lead_byte_next   = lead_byte;
    second_bits_next = second_bits;
    case (phase)
      PH_LEAD: begin
        if (!lead_byte[5]) begin
          res.emit = 1'b1;
          res.cp   = {5'b0, lead_byte[4:0], in_byte[5:0]};
        end else if (!last_byte) begin
          second_bits_next = in_byte[5:0];
          phase_next       = PH_SECOND;
        end
      end
      PH_SECOND: begin
        res.emit = 1'b1;
        res.cp   = {lead_byte[3:0], second_bits, in_byte[5:0]};
      end
      default: begin
        if (!in_byte[7]) begin
          res.emit = 1'b1;
          res.cp   = {8'b0, in_byte};
        end else begin
          lead_byte_next = in_byte;
          if (!last_byte) begin
            phase_next = PH_LEAD;
          end
        end
      end
    endcase
  end

  // state registers, updated on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      lead_byte   <= '0;
      second_bits <= '0;
    end else if (take) begin
      phase       <= phase_next;
      lead_byte   <= lead_byte_next;
      second_bits <= second_bits_next;
    end
  end

endmodule

FILE: sv/u2k_map.sv
// code point to koi-7 lookup, purely combinational
// depends on u2k_pkg for the table functions and dec_res_t

module u2k_map import u2k_pkg::*; (
  input  dec_res_t         res,
  output logic [CodeW-1:0] code
);

  logic [7:0] hi;
  logic [7:0] lo;

  assign hi = res.cp[15:8];
  assign lo = res.cp[7:0];

  // choose the block by the high byte of the code point
  always_comb begin
    case (hi)
      8'h00:   code = map_latin(lo);
      8'h04:   code = map_cyr(lo);
      default: code = map_sym(res.cp);
    endcase
  end

endmodule

FILE: sv/utf8_to_koi7_transcoder.sv
// top level of the utf-8 to koi-7 transcoder: handshake and result register
// depends on u2k_pkg, u2k_decode and u2k_map
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_ready  in_byte[7:0], last_byte
//   out      source     out_valid/out_ready  koi7_code[6:0]
//
// one byte is taken per cycle while the result register can accept it; decode and
// table lookup sit between the sequence state and the result register, so a code
// appears in the cycle after the byte that completes it. in_ready is high while the
// result register is empty or being drained in the same cycle. reset clears the
// phase to idle and empties the result register.

module utf8_to_koi7_transcoder import u2k_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] in_byte,
  input  logic             last_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CodeW-1:0] koi7_code
);

  logic             in_fire;
  dec_res_t         res;
  phase_t           phase;
  logic [CodeW-1:0] code;
  logic             out_valid_next;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  u2k_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (in_fire),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .res       (res),
    .phase     (phase)
  );

  u2k_map u_map (
    .res  (res),
    .code (code)
  );

  // result register
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (in_fire) begin
      out_valid_next = res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.emit) begin
      koi7_code <= code;
    end
  end

  // an ascii beat in idle yields a result on the next cycle
  a_ascii_emits: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE && !in_byte[7] |=> out_valid)
    else $error("ascii beat gave no result");

  // a lead byte in idle never yields a result
  a_lead_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_IDLE && in_byte[7] |=> !out_valid)
    else $error("lead byte gave a result");

  // the final byte of a string always leaves the tracker idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> phase == PH_IDLE)
    else $error("sequence left open after last byte");

  // the third beat of a sequence always completes a character
  a_third_emits: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_SECOND |=> out_valid && phase == PH_IDLE)
    else $error("three-byte sequence not completed");

endmodule

FILE: test/tb_top.sv
// self-checking testbench for the utf-8 to koi-7 transcoder
// needs u2k_pkg and the utf8_to_koi7_transcoder rtl; predicts every code and checks it in order

`timescale 1ns / 1ps

module tb_top import u2k_pkg::*; ();

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxGap     = 17;

  // koi-7 codes for u+0410 .. u+042f, reused for the small letters u+0430 .. u+044f
  localparam logic [CodeW-1:0] CYR_CODES [32] = '{
    7'h41, 7'h62, 7'h42, 7'h67, 7'h64, 7'h45, 7'h76, 7'h7a,
    7'h69, 7'h6a, 7'h4b, 7'h6c, 7'h4d, 7'h48, 7'h4f, 7'h70,
    7'h50, 7'h43, 7'h54, 7'h59, 7'h66, 7'h58, 7'h63, 7'h7e,
    7'h7b, 7'h7d, 7'h05, 7'h79, 7'h78, 7'h7c, 7'h60, 7'h71
  };

  // mapped symbols outside the latin and cyrillic blocks, used to steer stimulus
  localparam logic [15:0] SYMBOL_CPS [17] = '{
    16'h2015, 16'h2018, 16'h2019, 16'h2028, 16'h2032, 16'h203e,
    16'h212f, 16'h2191, 16'h2227, 16'h2228, 16'h2260, 16'h2261,
    16'h2264, 16'h2265, 16'h2283, 16'h23e8, 16'h25c7
  };

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [ByteW-1:0] in_byte;
  logic             last_byte;
  logic             out_valid;
  logic             out_ready;
  logic [CodeW-1:0] koi7_code;

  // predictor state
  phase_t           seq_phase;
  logic [7:0]       held_lead;
  logic [5:0]       held_second;
  logic [CodeW-1:0] pending_codes [$];

  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned rx_hold_len;
  int unsigned bytes_sent;
  int unsigned mismatch_count;
  int unsigned cycle_count = 0;

  utf8_to_koi7_transcoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .koi7_code (koi7_code)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // code point to koi-7 code
  function automatic logic [CodeW-1:0] koi7_of_cp(input logic [15:0] cp);
    logic [7:0]       lo;
    logic [7:0]       row_idx;
    logic [CodeW-1:0] code;
    begin
      lo      = cp[7:0];
      row_idx = lo - 8'h10;
      code    = 7'h00;
      if (cp[15:8] == 8'h00) begin
        if (lo >= 8'h61 && lo <= 8'h7a) begin
          code = lo[6:0] - 7'h20;
        end else begin
          case (lo)
            8'h5c: code = 7'h1d;
            8'h5e: code = 7'h5c;
            8'h60: code = 7'h00;
            8'h7b: code = 7'h0e;
            8'h7c: code = 7'h5e;
            8'h7d: code = 7'h0f;
            8'h7e: code = 7'h1f;
            8'h7f: code = 7'h00;
            8'hac: code = 7'h1f;
            8'hb0: code = 7'h19;
            8'hd7: code = 7'h06;
            8'hf7: code = 7'h1a;
            default: code = lo[7] ? 7'h00 : lo[6:0];
          endcase
        end
      end else if (cp[15:8] == 8'h04) begin
        if (lo >= 8'h10 && lo <= 8'h4f) begin
          code = CYR_CODES[row_idx[4:0]];
        end else begin
          case (lo)
            8'h01, 8'h04, 8'h51, 8'h54: code = 7'h45;
            8'h06, 8'h07, 8'h56, 8'h57: code = 7'h49;
            8'h90, 8'h91:               code = 7'h67;
            default:                    code = 7'h00;
          endcase
        end
      end else begin
        case (cp)
          16'h2015: code = 7'h15;
          16'h2018: code = 7'h10;
          16'h2019: code = 7'h1b;
          16'h2028: code = 7'h0a;
          16'h2032: code = 7'h27;
          16'h203e: code = 7'h5c;
          16'h212f: code = 7'h45;
          16'h2191: code = 7'h16;
          16'h2227: code = 7'h26;
          16'h2228: code = 7'h1e;
          16'h2260: code = 7'h18;
          16'h2261: code = 7'h1d;
          16'h2264: code = 7'h0e;
          16'h2265: code = 7'h0f;
          16'h2283: code = 7'h1c;
          16'h23e8: code = 7'h17;
          16'h25c7: code = 7'h24;
          default:  code = 7'h00;
        endcase
      end
      return code;
    end
  endfunction

  // advance the sequence state by one accepted byte, queueing any completed code
  task automatic decode_byte(input logic [7:0] b, input logic last);
    begin
      case (seq_phase)
        PH_LEAD: begin
          if (!held_lead[5]) begin
            pending_codes.push_back(koi7_of_cp({5'b0, held_lead[4:0], b[5:0]}));
            seq_phase = PH_IDLE;
          end else if (last) begin
            // three-byte sequence cut short after its second byte
            seq_phase = PH_IDLE;
          end else begin
            held_second = b[5:0];
            seq_phase   = PH_SECOND;
          end
        end
        PH_SECOND: begin
          pending_codes.push_back(koi7_of_cp({held_lead[3:0], held_second, b[5:0]}));
          seq_phase = PH_IDLE;
        end
        default: begin
          seq_phase = PH_IDLE;
          if (!b[7]) begin
            pending_codes.push_back(koi7_of_cp({8'h00, b}));
          end else begin
            held_lead = b;
            if (!last) begin
              seq_phase = PH_LEAD;
            end
          end
        end
      endcase
    end
  endtask

  // offer one byte after a random gap and wait for the beat
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    begin
      gap = (in_gap_max == 0) ? 0 : $urandom_range(in_gap_max, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid  <= 1'b1;
      in_byte   <= b;
      last_byte <= last;
      do @(posedge clk); while (!in_ready);
      decode_byte(b, last);
      bytes_sent++;
    end
  endtask

  // stop offering and wait for every predicted code to come out
  task automatic wait_drained();
    begin
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_codes.size() != 0);
    end
  endtask

  // one character, mostly well formed, sometimes noise or a cut-short sequence
  task automatic send_random_char();
    int unsigned kind;
    logic [15:0] cp;
    logic        fin;
    begin
      kind = $urandom_range(99, 0);
      fin  = ($urandom_range(9, 0) == 0);
      if (kind < 28) begin
        send_byte(8'($urandom_range(127, 0)), fin);
      end else if (kind < 50) begin
        send_byte(8'hd0 | 8'($urandom_range(1, 0)), 1'b0);
        send_byte(8'h80 | 8'($urandom_range(63, 0)), fin);
      end else if (kind < 62) begin
        // any two-byte lead; continuation not always well formed
        send_byte(8'hc0 | 8'($urandom_range(31, 0)), 1'b0);
        if ($urandom_range(3, 0) == 0) begin
          send_byte(8'($urandom_range(255, 0)), fin);
        end else begin
          send_byte(8'h80 | 8'($urandom_range(63, 0)), fin);
        end
      end else if (kind < 72) begin
        cp = SYMBOL_CPS[$urandom_range(16, 0)];
        send_byte(8'he0 | 8'(cp[15:12]), 1'b0);
        send_byte(8'h80 | 8'(cp[11:6]), 1'b0);
        send_byte(8'h80 | 8'(cp[5:0]), fin);
      end else if (kind < 84) begin
        send_byte(8'he0 | 8'($urandom_range(15, 0)), 1'b0);
        send_byte(8'h80 | 8'($urandom_range(63, 0)), 1'b0);
        send_byte(8'h80 | 8'($urandom_range(63, 0)), fin);
      end else if (kind < 94) begin
        send_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
      end else if (kind < 97) begin
        // lead alone on the last byte
        send_byte(8'h80 | 8'($urandom_range(127, 0)), 1'b1);
      end else begin
        // three-byte sequence ending after its second byte
        send_byte(8'he0 | 8'($urandom_range(31, 0)), 1'b0);
        send_byte(8'($urandom_range(255, 0)), 1'b1);
      end
    end
  endtask

  task automatic test_directed_cases();
    begin
      in_gap_max  = MaxGap;
      out_gap_max = MaxGap;
      // ascii extremes and case folding
      send_byte(8'h00, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h7a, 1'b0);
      send_byte(8'h5c, 1'b0);
      send_byte(8'h7e, 1'b0);
      // latin-1 degree sign
      send_byte(8'hc2, 1'b0);
      send_byte(8'hb0, 1'b0);
      // first and last cyrillic row entries
      send_byte(8'hd0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'hd1, 1'b0);
      send_byte(8'h8f, 1'b0);
      // three-byte symbols at both ends of the symbol range
      send_byte(8'he2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h95, 1'b0);
      send_byte(8'he2, 1'b0);
      send_byte(8'h97, 1'b0);
      send_byte(8'h87, 1'b0);
      // continuation byte used as a lead, followed by a plain letter as continuation
      send_byte(8'h80, 1'b0);
      send_byte(8'h41, 1'b0);
      // highest lead, all ones
      send_byte(8'hff, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'hbf, 1'b0);
      // cut-short sequences, then a complete character on the last byte
      send_byte(8'hd0, 1'b1);
      send_byte(8'he2, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'h41, 1'b1);
    end
  endtask

  task automatic test_random_text(input int unsigned n_bytes, input int unsigned in_max,
                                  input int unsigned out_max);
    int unsigned stop_at;
    begin
      in_gap_max  = in_max;
      out_gap_max = out_max;
      stop_at     = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
        send_random_char();
      end
    end
  endtask

  // receiver holds off for a long stretch while bytes keep coming
  task automatic test_output_backpressure();
    int unsigned i;
    begin
      in_gap_max  = 0;
      out_gap_max = 3;
      rx_hold_len = 300;
      for (i = 0; i < 60; i++) begin
        send_byte(8'($urandom_range(127, 0)), 1'b0);
      end
    end
  endtask

  // sender pauses until every code is out, then resumes mid-stream
  task automatic test_drain_pause();
    int unsigned i;
    begin
      in_gap_max  = MaxGap;
      out_gap_max = MaxGap;
      for (i = 0; i < 4; i++) begin
        send_random_char();
        send_random_char();
        wait_drained();
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end
    end
  endtask

  // receiver: random stalls, checks every beat against the oldest prediction
  initial begin
    int unsigned      stall;
    logic [CodeW-1:0] want;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        stall       = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall = (out_gap_max == 0) ? 0 : $urandom_range(out_gap_max, 0);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_codes.size() == 0) begin
        $display("%0t: koi7_code %h with no code pending, expected none", $time, koi7_code);
        mismatch_count++;
      end else begin
        want = pending_codes.pop_front();
        if (koi7_code !== want) begin
          $display("%0t: koi7_code mismatch, expected %h, actual %h", $time, want,
                   koi7_code);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_byte        = '0;
    last_byte      = 1'b0;
    seq_phase      = PH_IDLE;
    held_lead      = '0;
    held_second    = '0;
    in_gap_max     = MaxGap;
    out_gap_max    = MaxGap;
    rx_hold_len    = 0;
    bytes_sent     = 0;
    mismatch_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_text(750, MaxGap, MaxGap);
    test_output_backpressure();
    test_drain_pause();
    test_random_text(200, 0, 0);
    test_random_text(200, 0, MaxGap);
    test_random_text(200, MaxGap, 0);

    // let the last beats drain, then keep watching for stray output
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_codes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
